### src/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// shared types, register indexes, reset values and the mfm bit rule
// ----------------------------------------------------------------------------
`default_nettype none

package mss_pkg;

  localparam int unsigned POS_W  = 11;
  localparam int unsigned ACC_W  = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POSTAMBLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILLER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFICIT   = 3'd4;

  // reset values
  localparam logic [7:0] RST_PREAMBLE  = 8'd40;
  localparam logic [9:0] RST_DATA      = 10'd275;
  localparam logic [7:0] RST_POSTAMBLE = 8'd40;
  localparam logic [7:0] RST_FILLER    = 8'd35;
  localparam logic [4:0] RST_DEFICIT   = 5'd10;

  localparam logic signed [ACC_W:0] ACC_FLOOR  = -7'sd32;
  localparam logic signed [ACC_W:0] ACC_REFILL = 7'sd16;

  // frame boundaries derived from the length registers
  typedef struct packed {
    logic [7:0]       data_start;
    logic [POS_W-1:0] data_stop;
    logic [POS_W-1:0] fixed_len;
    logic [4:0]       deficit;
  } frame_cfg_t;

  // clock cell set only when this data bit and the one before are both 0
  function automatic logic [15:0] mfm_encode(input logic [7:0] b, input logic prev);
    logic [15:0] w;
    logic        p;
    w = '0;
    for (int i = 7; i >= 0; i--) begin
      p = (i == 7) ? prev : b[i+1];
      w[2*i+1] = ~p & ~b[i];
      w[2*i]   = b[i];
    end
    return w;
  endfunction

endpackage

`default_nettype wire

### src/mss_cfg.sv
// ----------------------------------------------------------------------------
// mss_cfg
// length and deficit registers, with registered frame boundaries
// ----------------------------------------------------------------------------
`default_nettype none

module mss_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            wr_en,
  input  wire logic [mss_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [mss_pkg::CFG_DATA_W-1:0] wr_data,
  output mss_pkg::frame_cfg_t                  frame_cfg
);
  import mss_pkg::*;

  logic [7:0] preamble_r, preamble_nxt;
  logic [9:0] data_r, data_nxt;
  logic [7:0] postamble_r, postamble_nxt;
  logic [7:0] filler_r, filler_nxt;
  logic [4:0] deficit_r, deficit_nxt;

  logic [POS_W-1:0] data_stop_nxt;
  logic [POS_W-1:0] fixed_len_nxt;
  frame_cfg_t       frame_cfg_r;

  // register values after this cycle's write
  always_comb begin
    preamble_nxt  = preamble_r;
    data_nxt      = data_r;
    postamble_nxt = postamble_r;
    filler_nxt    = filler_r;
    deficit_nxt   = deficit_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_PREAMBLE:  preamble_nxt  = wr_data[7:0];
        CFG_DATA:      data_nxt      = wr_data[9:0];
        CFG_POSTAMBLE: postamble_nxt = wr_data[7:0];
        CFG_FILLER:    filler_nxt    = wr_data[7:0];
        CFG_DEFICIT:   deficit_nxt   = wr_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preamble_r  <= RST_PREAMBLE;
      data_r      <= RST_DATA;
      postamble_r <= RST_POSTAMBLE;
      filler_r    <= RST_FILLER;
      deficit_r   <= RST_DEFICIT;
    end else begin
      preamble_r  <= preamble_nxt;
      data_r      <= data_nxt;
      postamble_r <= postamble_nxt;
      filler_r    <= filler_nxt;
      deficit_r   <= deficit_nxt;
    end
  end

  // worst case 255 + 1023 + 255 + 255 fits in the position width
  // boundaries follow a write in the same cycle as the registers do
  assign data_stop_nxt = {3'b000, preamble_nxt} + {1'b0, data_nxt};
  assign fixed_len_nxt = data_stop_nxt + {3'b000, postamble_nxt} + {3'b000, filler_nxt};

  always_ff @(posedge clk) begin
    frame_cfg_r.data_start <= preamble_nxt;
    frame_cfg_r.data_stop  <= data_stop_nxt;
    frame_cfg_r.fixed_len  <= fixed_len_nxt;
    frame_cfg_r.deficit    <= deficit_nxt;
  end

  assign frame_cfg = frame_cfg_r;

endmodule

`default_nettype wire

### src/mss_frame.sv
// ----------------------------------------------------------------------------
// mss_frame
// sector frame position, cell error accumulator and mfm word forming
// ----------------------------------------------------------------------------
`default_nettype none

module mss_frame (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mss_pkg::frame_cfg_t frame_cfg,
  input  wire logic                step,
  input  wire logic [7:0]          data_byte,
  input  wire logic                start_track,
  output logic [15:0]              mfm_word,
  output logic                     took_byte,
  output logic                     sector_end
);
  import mss_pkg::*;

  logic [POS_W-1:0]        pos_r, pos_nxt, pos_eff, pos_inc;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, acc_eff;
  logic signed [ACC_W:0]   acc_diff, acc_sat;
  logic                    last_r, prev_eff;
  logic [7:0]              byte_out;

  always_comb begin
    pos_eff  = start_track ? '0 : pos_r;
    acc_eff  = start_track ? '0 : acc_r;
    prev_eff = start_track ? 1'b0 : last_r;
    pos_inc  = pos_eff + 11'd1;

    acc_diff = {acc_eff[ACC_W-1], acc_eff} - $signed({2'b00, frame_cfg.deficit});
    acc_sat  = (acc_diff < ACC_FLOOR) ? ACC_FLOOR : acc_diff;

    byte_out   = '0;
    took_byte  = 1'b0;
    sector_end = 1'b0;
    pos_nxt    = '0;
    acc_nxt    = acc_eff;

    if (pos_eff < frame_cfg.fixed_len) begin
      if (pos_eff >= {3'b000, frame_cfg.data_start} && pos_eff < frame_cfg.data_stop) begin
        byte_out  = data_byte;
        took_byte = 1'b1;
      end
      if (pos_inc == frame_cfg.fixed_len) begin
        if (acc_sat[ACC_W]) begin
          // owe a byte: one extra zero byte closes the sector
          acc_nxt = ACC_W'(acc_sat + ACC_REFILL);
          pos_nxt = frame_cfg.fixed_len;
        end else begin
          acc_nxt    = acc_sat[ACC_W-1:0];
          sector_end = 1'b1;
        end
      end else begin
        pos_nxt = pos_inc;
      end
    end else begin
      // extra byte, or position left past a shortened frame
      sector_end = 1'b1;
    end

    mfm_word = mfm_encode(byte_out, prev_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      acc_r  <= '0;
      last_r <= 1'b0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      acc_r  <= acc_nxt;
      last_r <= byte_out[0];
    end
  end

endmodule

`default_nettype wire

### src/mfm_sector_stream_generator.sv
// ----------------------------------------------------------------------------
// mfm_sector_stream_generator
// one 16-bit mfm word per request, framed into sectors with gap bytes
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    in_data_byte[8], in_start_track
//  out      output     out_valid/out_ready  out_mfm_word[16], out_took_byte,
//                                            out_sector_end
//  cfg      input      cfg_valid/cfg_ready  cfg_index[3], cfg_data[10]
//
//  one word per clock sustained while out_ready stays high; a taken request word
//  passes the input register, then frame logic into the output register
//  the throughput is set by the frame position / accumulator update, a
//  combinational step between the input and output registers
//  reset is synchronous and active low; lengths return to 40/275/40/35,
//  deficit to 10, and the frame restarts at the preamble
//  with out_ready low the output word holds, the input register takes one
//  more word and then in_ready drops; cfg_ready is always high
//
`default_nettype none

module mfm_sector_stream_generator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request words
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      in_data_byte,
  input  wire logic                            in_start_track,
  // mfm words
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [15:0]                          out_mfm_word,
  output logic                                 out_took_byte,
  output logic                                 out_sector_end,
  // register writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mss_pkg::*;

  frame_cfg_t  frame_cfg;

  // input register
  logic        a_valid_r;
  logic [7:0]  a_byte_r;
  logic        a_start_r;

  // output register
  logic        o_valid_r;
  logic [15:0] o_word_r;
  logic        o_took_r;
  logic        o_end_r;

  logic        advance;
  logic [15:0] f_word;
  logic        f_took;
  logic        f_end;

  assign cfg_ready = 1'b1;

  mss_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_valid),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .frame_cfg (frame_cfg)
  );

  // the word in the input register moves on when the output slot is free
  assign advance  = a_valid_r && (!o_valid_r || out_ready);
  assign in_ready = !a_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_byte_r  <= in_data_byte;
      a_start_r <= in_start_track;
    end
  end

  // frame state steps once per word that reaches the output register
  mss_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_cfg   (frame_cfg),
    .step        (advance),
    .data_byte   (a_byte_r),
    .start_track (a_start_r),
    .mfm_word    (f_word),
    .took_byte   (f_took),
    .sector_end  (f_end)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (advance) begin
      o_valid_r <= 1'b1;
    end else if (out_ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_word_r <= f_word;
      o_took_r <= f_took;
      o_end_r  <= f_end;
    end
  end

  assign out_valid      = o_valid_r;
  assign out_mfm_word   = o_word_r;
  assign out_took_byte  = o_took_r;
  assign out_sector_end = o_end_r;

endmodule

`default_nettype wire

### src/mss_checker.sv
// ----------------------------------------------------------------------------
// mss_checker
// port-level checks on the mfm word stream
// ----------------------------------------------------------------------------
`default_nettype none

module mss_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_mfm_word,
  input wire logic        out_took_byte,
  input wire logic        out_sector_end
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mfm_word)
      && $stable(out_took_byte) && $stable(out_sector_end))
    else $error("stalled output word changed");

  // mfm never puts two adjacent one cells
  a_no_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_mfm_word & (out_mfm_word >> 1)) == 16'h0000))
    else $error("adjacent one cells in mfm word");

  // gap bytes carry zero data cells
  a_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_took_byte |-> ((out_mfm_word & 16'h5555) == 16'h0000))
    else $error("gap byte with data cells set");

  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind mfm_sector_stream_generator mss_checker u_mss_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_mfm_word   (out_mfm_word),
  .out_took_byte  (out_took_byte),
  .out_sector_end (out_sector_end)
);

`default_nettype wire
